// File: rtl/core/rhc_pkg.sv
`timescale 1ns / 1ps

package rhc_pkg;

  // Channel code width and derived datapath widths
  localparam int CHANNEL_BITS = 8;
  localparam int HUE_BITS     = 9;
  // Quotient bits resolved by the divider, one per pipeline stage
  localparam int QUO_BITS     = (CHANNEL_BITS > HUE_BITS) ? CHANNEL_BITS : HUE_BITS;
  // Dividend and remainder width inside the divider
  localparam int DIV_W        = QUO_BITS + CHANNEL_BITS;
  // Sector offset k * chroma + diff, below 6 * chroma
  localparam int OFS_BITS     = CHANNEL_BITS + 3;
  // Hue numerator, 60 times the sector offset
  localparam int HNUM_BITS    = OFS_BITS + 6;
  localparam int DEG_SECTOR   = 60;

  // Fields that ride alongside the division
  typedef struct packed {
    logic [CHANNEL_BITS-1:0] brightness;
    logic                    undef;
  } rhc_side_t;

  // Operands for both division lanes
  typedef struct packed {
    logic [DIV_W-1:0]        sat_num;
    logic [CHANNEL_BITS-1:0] sat_den;
    logic [DIV_W-1:0]        hue_num;
    logic [CHANNEL_BITS-1:0] hue_den;
  } rhc_div_op_t;

endpackage

// File: rtl/core/rhc_front.sv
`timescale 1ns / 1ps

module rhc_front import rhc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [CHANNEL_BITS-1:0] red_i,
  input  logic [CHANNEL_BITS-1:0] green_i,
  input  logic [CHANNEL_BITS-1:0] blue_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output rhc_div_op_t             op_o,
  output rhc_side_t               side_o
);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  localparam logic [2:0] MULT_RED   = 3'd0;
  localparam logic [2:0] MULT_GREEN = 3'd2;
  localparam logic [2:0] MULT_BLUE  = 3'd4;
  localparam logic [2:0] MULT_WRAP  = 3'd6;

  sector_e                        sec;
  logic        [CHANNEL_BITS-1:0] max_val;
  logic        [CHANNEL_BITS-1:0] min_val;
  logic signed [CHANNEL_BITS:0]   diff;
  logic        [2:0]              mult;

  logic                           vld_a_q, vld_b_q;
  logic                           rdy_a, rdy_b;
  logic        [CHANNEL_BITS-1:0] max_q;
  logic        [CHANNEL_BITS-1:0] chroma_q;
  logic signed [CHANNEL_BITS:0]   diff_q;
  logic        [2:0]              mult_q;

  logic        [OFS_BITS-1:0]     ofs;
  logic        [HNUM_BITS-1:0]    hue_num;
  logic        [2*CHANNEL_BITS-1:0] sat_prod;
  logic                           gray;
  rhc_div_op_t                    op_d, op_q;
  rhc_side_t                      side_d, side_q;

  // Advance a stage when it is empty or its successor moves
  assign rdy_b   = ~vld_b_q | ready_i;
  assign rdy_a   = ~vld_a_q | rdy_b;
  assign ready_o = rdy_a;

  // Pick the largest channel, ties to red then green
  always_comb begin
    if (red_i >= green_i && red_i >= blue_i) begin
      sec     = SEC_RED;
      max_val = red_i;
    end else if (green_i >= blue_i) begin
      sec     = SEC_GREEN;
      max_val = green_i;
    end else begin
      sec     = SEC_BLUE;
      max_val = blue_i;
    end
    min_val = red_i;
    if (green_i < min_val) min_val = green_i;
    if (blue_i < min_val) min_val = blue_i;
  end

  // Form the signed offset within the sector and the sector multiple
  always_comb begin
    case (sec)
      SEC_RED: begin
        diff = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
        mult = diff[CHANNEL_BITS] ? MULT_WRAP : MULT_RED;
      end
      SEC_GREEN: begin
        diff = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
        mult = MULT_GREEN;
      end
      SEC_BLUE: begin
        diff = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
        mult = MULT_BLUE;
      end
      default: begin
        diff = '0;
        mult = MULT_RED;
      end
    endcase
  end

  // Stage A: extremes, chroma and sector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (rdy_a) begin
      vld_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      max_q    <= max_val;
      chroma_q <= max_val - min_val;
      diff_q   <= diff;
      mult_q   <= mult;
    end
  end

  // Build both dividends; swap a zero divisor for one so the quotient is zero
  always_comb begin
    gray     = (chroma_q == '0);
    ofs      = OFS_BITS'(mult_q) * OFS_BITS'(chroma_q) + OFS_BITS'(diff_q);
    hue_num  = HNUM_BITS'(ofs) * HNUM_BITS'(DEG_SECTOR);
    sat_prod = {chroma_q, {CHANNEL_BITS{1'b0}}} - (2*CHANNEL_BITS)'(chroma_q);

    op_d.sat_num = DIV_W'(sat_prod);
    op_d.sat_den = (max_q == '0) ? CHANNEL_BITS'(1) : max_q;
    op_d.hue_num = DIV_W'(hue_num);
    op_d.hue_den = gray ? CHANNEL_BITS'(1) : chroma_q;

    side_d.brightness = max_q;
    side_d.undef      = gray;
  end

  // Stage B: division operands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else if (rdy_b) begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && vld_a_q) begin
      op_q   <= op_d;
      side_q <= side_d;
    end
  end

  assign valid_o = vld_b_q;
  assign op_o    = op_q;
  assign side_o  = side_q;

endmodule

// File: rtl/core/rhc_div.sv
`timescale 1ns / 1ps

module rhc_div import rhc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  rhc_div_op_t             op_i,
  input  rhc_side_t               side_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [QUO_BITS-1:0]     sat_quo_o,
  output logic [QUO_BITS-1:0]     hue_quo_o,
  output rhc_side_t               side_o
);

  // Per-stage registers; remainder and divisor are not kept after the last step
  logic                    vld_q     [QUO_BITS];
  logic                    rdy       [QUO_BITS+1];
  logic [QUO_BITS-1:0]     sat_quo_q [QUO_BITS];
  logic [QUO_BITS-1:0]     hue_quo_q [QUO_BITS];
  rhc_side_t               side_q    [QUO_BITS];
  logic [DIV_W-1:0]        sat_rem_q [QUO_BITS-1];
  logic [DIV_W-1:0]        hue_rem_q [QUO_BITS-1];
  logic [CHANNEL_BITS-1:0] sat_den_q [QUO_BITS-1];
  logic [CHANNEL_BITS-1:0] hue_den_q [QUO_BITS-1];

  assign rdy[QUO_BITS] = ready_i;
  assign ready_o       = rdy[0];

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
    localparam int Shift = QUO_BITS - 1 - k;

    logic                    vld_in;
    logic [QUO_BITS-1:0]     sat_quo_in, hue_quo_in;
    logic [DIV_W-1:0]        sat_rem_in, hue_rem_in;
    logic [CHANNEL_BITS-1:0] sat_den_in, hue_den_in;
    rhc_side_t               side_in;
    logic [DIV_W-1:0]        sat_dsh, hue_dsh;
    logic                    sat_ge, hue_ge;
    logic [DIV_W-1:0]        sat_rem_d, hue_rem_d;
    logic [QUO_BITS-1:0]     sat_quo_d, hue_quo_d;

    // Take operands from the port or the previous step
    if (k == 0) begin : g_first
      assign vld_in     = valid_i;
      assign sat_quo_in = '0;
      assign hue_quo_in = '0;
      assign sat_rem_in = op_i.sat_num;
      assign hue_rem_in = op_i.hue_num;
      assign sat_den_in = op_i.sat_den;
      assign hue_den_in = op_i.hue_den;
      assign side_in    = side_i;
    end else begin : g_next
      assign vld_in     = vld_q[k-1];
      assign sat_quo_in = sat_quo_q[k-1];
      assign hue_quo_in = hue_quo_q[k-1];
      assign sat_rem_in = sat_rem_q[k-1];
      assign hue_rem_in = hue_rem_q[k-1];
      assign sat_den_in = sat_den_q[k-1];
      assign hue_den_in = hue_den_q[k-1];
      assign side_in    = side_q[k-1];
    end

    assign rdy[k] = ~vld_q[k] | rdy[k+1];

    // Resolve one quotient bit in each lane
    always_comb begin
      sat_dsh   = DIV_W'(sat_den_in) << Shift;
      hue_dsh   = DIV_W'(hue_den_in) << Shift;
      sat_ge    = (sat_rem_in >= sat_dsh);
      hue_ge    = (hue_rem_in >= hue_dsh);
      sat_rem_d = sat_ge ? (sat_rem_in - sat_dsh) : sat_rem_in;
      hue_rem_d = hue_ge ? (hue_rem_in - hue_dsh) : hue_rem_in;
      sat_quo_d        = sat_quo_in;
      sat_quo_d[Shift] = sat_ge;
      hue_quo_d        = hue_quo_in;
      hue_quo_d[Shift] = hue_ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vld_in) begin
        sat_quo_q[k] <= sat_quo_d;
        hue_quo_q[k] <= hue_quo_d;
        side_q[k]    <= side_in;
      end
    end

    // Carry remainder and divisor onward except from the last step
    if (k < QUO_BITS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (rdy[k] && vld_in) begin
          sat_rem_q[k] <= sat_rem_d;
          hue_rem_q[k] <= hue_rem_d;
          sat_den_q[k] <= sat_den_in;
          hue_den_q[k] <= hue_den_in;
        end
      end
    end
  end

  assign valid_o   = vld_q[QUO_BITS-1];
  assign sat_quo_o = sat_quo_q[QUO_BITS-1];
  assign hue_quo_o = hue_quo_q[QUO_BITS-1];
  assign side_o    = side_q[QUO_BITS-1];

endmodule

// File: rtl/core/rgb_to_hsv_convert.sv
`timescale 1ns / 1ps

// RGB to HSV pixel converter.
// Input channel: in_valid_i with red_i, green_i, blue_i; a transaction
// completes on a rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o with hue_o (degrees 0..359), saturation_o,
// brightness_o and hue_undefined_o; a transaction completes with
// out_valid_o high and out_stall_i low.
// Two stages find the extremes and build the dividends, then a restoring
// divider resolves one quotient bit per stage for saturation and hue side
// by side. Throughput is one pixel per cycle while out_stall_i is low;
// the divider pipeline sets the depth.
// Gray and black pixels give hue 0, saturation 0 and hue_undefined_o high.
// Reset clears every stage valid bit, so no transaction is presented
// until new pixels arrive.
// When out_stall_i is held, empty stages still fill, so in_stall_o rises
// only once every stage holds a pixel; nothing is lost or repeated.
module rgb_to_hsv_convert import rhc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CHANNEL_BITS-1:0] red_i,
  input  logic [CHANNEL_BITS-1:0] green_i,
  input  logic [CHANNEL_BITS-1:0] blue_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [HUE_BITS-1:0]     hue_o,
  output logic [CHANNEL_BITS-1:0] saturation_o,
  output logic [CHANNEL_BITS-1:0] brightness_o,
  output logic                    hue_undefined_o
);

  logic                front_rdy;
  logic                op_vld, op_rdy;
  rhc_div_op_t         op;
  rhc_side_t           side_front, side_out;
  logic [QUO_BITS-1:0] sat_quo, hue_quo;

  rhc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (front_rdy),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .valid_o (op_vld),
    .ready_i (op_rdy),
    .op_o    (op),
    .side_o  (side_front)
  );

  rhc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (op_vld),
    .ready_o   (op_rdy),
    .op_i      (op),
    .side_i    (side_front),
    .valid_o   (out_valid_o),
    .ready_i   (~out_stall_i),
    .sat_quo_o (sat_quo),
    .hue_quo_o (hue_quo),
    .side_o    (side_out)
  );

  // Trim quotients to the result widths
  assign in_stall_o      = ~front_rdy;
  assign hue_o           = hue_quo[HUE_BITS-1:0];
  assign saturation_o    = sat_quo[CHANNEL_BITS-1:0];
  assign brightness_o    = side_out.brightness;
  assign hue_undefined_o = side_out.undef;

endmodule

// File: tb/rgb_to_hsv_convert_tb.sv
`timescale 1ns / 1ps

module rgb_to_hsv_convert_tb import rhc_pkg::*;;

  localparam int PIPE_LATENCY = 2 + QUO_BITS;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int FULL_TURN    = 360;
  localparam int GREEN_SECTOR = 2;
  localparam int BLUE_SECTOR  = 4;
  localparam int CHAN_MAX     = (1 << CHANNEL_BITS) - 1;
  localparam int IDLE_MAX     = 11;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue;
    logic [CHANNEL_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0] brightness;
    logic                    hue_undefined;
  } hsv_pixel_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [CHANNEL_BITS-1:0] red_i;
  logic [CHANNEL_BITS-1:0] green_i;
  logic [CHANNEL_BITS-1:0] blue_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [HUE_BITS-1:0]     hue_o;
  logic [CHANNEL_BITS-1:0] saturation_o;
  logic [CHANNEL_BITS-1:0] brightness_o;
  logic                    hue_undefined_o;

  hsv_pixel_t  pending_hsv_q[$];
  int          error_count    = 0;
  int unsigned src_idle_max   = IDLE_MAX;
  int unsigned sink_stall_max = IDLE_MAX;

  rgb_to_hsv_convert dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hue_o           (hue_o),
    .saturation_o    (saturation_o),
    .brightness_o    (brightness_o),
    .hue_undefined_o (hue_undefined_o)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Work out hue, saturation and value of one pixel with exact integer maths
  function automatic hsv_pixel_t predict_hsv(input logic [CHANNEL_BITS-1:0] red,
                                             input logic [CHANNEL_BITS-1:0] green,
                                             input logic [CHANNEL_BITS-1:0] blue);
    hsv_pixel_t pix;
    int         r;
    int         g;
    int         b;
    int         hi;
    int         lo;
    int         chroma;
    int         numer;
    r   = int'(red);
    g   = int'(green);
    b   = int'(blue);
    hi  = r;
    lo  = r;
    pix = '0;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    chroma         = hi - lo;
    pix.brightness = hi[CHANNEL_BITS-1:0];
    if (chroma == 0) begin
      pix.hue_undefined = 1'b1;
    end else begin
      pix.saturation = CHANNEL_BITS'((CHAN_MAX * chroma) / hi);
      // Ties for the maximum go to red first, then green
      if (r == hi) begin
        numer = DEG_SECTOR * (g - b);
      end else if (g == hi) begin
        numer = DEG_SECTOR * (GREEN_SECTOR * chroma + (b - r));
      end else begin
        numer = DEG_SECTOR * (BLUE_SECTOR * chroma + (r - g));
      end
      if (numer < 0) numer += FULL_TURN * chroma;
      pix.hue = HUE_BITS'(numer / chroma);
    end
    return pix;
  endfunction

  // Present one pixel after a random idle gap and hold it until taken
  task automatic send_pixel(input int red, input int green, input int blue);
    int unsigned gap;
    logic        stalled;
    gap = $urandom_range(0, src_idle_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i      <= CHANNEL_BITS'(red);
    green_i    <= CHANNEL_BITS'(green);
    blue_i     <= CHANNEL_BITS'(blue);
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    pending_hsv_q.push_back(predict_hsv(CHANNEL_BITS'(red), CHANNEL_BITS'(green),
                                        CHANNEL_BITS'(blue)));
  endtask

  // Drive the output stall: random hold, then wait for one transaction
  initial begin : sink_stall
    int unsigned hold;
    logic        taken;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = $urandom_range(0, sink_stall_max);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        taken = out_valid_o;
        @(posedge clk_i);
      end while (!taken);
    end
  end

  // Compare each accepted result with the oldest pending prediction
  always @(negedge clk_i) begin
    hsv_pixel_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_hsv_q.size() == 0) begin
        $error("result with nothing pending: hue %0d sat %0d val %0d undef %0b",
               hue_o, saturation_o, brightness_o, hue_undefined_o);
        error_count++;
      end else begin
        want = pending_hsv_q.pop_front();
        if (hue_o !== want.hue) begin
          $error("hue: expected %0d, got %0d", want.hue, hue_o);
          error_count++;
        end
        if (saturation_o !== want.saturation) begin
          $error("saturation: expected %0d, got %0d", want.saturation, saturation_o);
          error_count++;
        end
        if (brightness_o !== want.brightness) begin
          $error("brightness: expected %0d, got %0d", want.brightness, brightness_o);
          error_count++;
        end
        if (hue_undefined_o !== want.hue_undefined) begin
          $error("hue_undefined: expected %0b, got %0b", want.hue_undefined,
                 hue_undefined_o);
          error_count++;
        end
      end
    end
  end

  // Corners: black, white, grays, primaries, ties, wrap below zero degrees
  task automatic test_corner_pixels();
    src_idle_max   = IDLE_MAX;
    sink_stall_max = IDLE_MAX;
    send_pixel(0, 0, 0);
    send_pixel(255, 255, 255);
    send_pixel(128, 128, 128);
    send_pixel(1, 1, 1);
    send_pixel(255, 0, 0);
    send_pixel(0, 255, 0);
    send_pixel(0, 0, 255);
    send_pixel(255, 255, 0);
    send_pixel(0, 255, 255);
    send_pixel(255, 0, 255);
    send_pixel(200, 200, 100);
    send_pixel(200, 100, 200);
    send_pixel(100, 200, 200);
    send_pixel(255, 0, 1);
    send_pixel(1, 0, 0);
    send_pixel(0, 0, 1);
    send_pixel(0, 1, 0);
    send_pixel(255, 254, 254);
    send_pixel(254, 255, 254);
    send_pixel(254, 254, 255);
    send_pixel(170, 85, 170);
    send_pixel(85, 170, 85);
    send_pixel(1, 255, 0);
    send_pixel(255, 1, 255);
  endtask

  // Uniform pixels, idling switched on and off in stretches
  task automatic test_random_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        src_idle_max   = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
        sink_stall_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
      end
      send_pixel($urandom_range(0, CHAN_MAX), $urandom_range(0, CHAN_MAX),
                 $urandom_range(0, CHAN_MAX));
    end
  endtask

  // Nearly gray pixels: small chroma and frequent ties
  task automatic test_near_gray(input int count);
    int lo;
    int spread;
    src_idle_max   = IDLE_MAX;
    sink_stall_max = IDLE_MAX;
    for (int i = 0; i < count; i++) begin
      lo     = $urandom_range(0, CHAN_MAX);
      spread = $urandom_range(0, 3);
      if (lo + spread > CHAN_MAX) lo = CHAN_MAX - spread;
      send_pixel(lo + $urandom_range(0, spread), lo + $urandom_range(0, spread),
                 lo + $urandom_range(0, spread));
    end
  endtask

  // Full rate: no idling on either side
  task automatic test_back_to_back(input int count);
    src_idle_max   = 0;
    sink_stall_max = 0;
    for (int i = 0; i < count; i++) begin
      send_pixel($urandom_range(0, CHAN_MAX), $urandom_range(0, CHAN_MAX),
                 $urandom_range(0, CHAN_MAX));
    end
  endtask

  // Heavy output stalls with a source that never idles, so the pipe fills
  task automatic test_output_backpressure(input int count);
    src_idle_max   = 0;
    sink_stall_max = IDLE_MAX;
    for (int i = 0; i < count; i++) begin
      send_pixel($urandom_range(0, CHAN_MAX), $urandom_range(0, CHAN_MAX),
                 $urandom_range(0, CHAN_MAX));
    end
  endtask

  initial begin : run_tests
    int drain_cycles;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    red_i      <= '0;
    green_i    <= '0;
    blue_i     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_pixels();
    test_random_pixels(700);
    test_near_gray(300);
    test_back_to_back(300);
    test_output_backpressure(300);
    in_valid_i <= 1'b0;

    // Drain pending results, then allow time for any stray transaction
    drain_cycles = 0;
    while (pending_hsv_q.size() > 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);

    if (pending_hsv_q.size() != 0) begin
      $error("%0d results never arrived", pending_hsv_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin : watchdog
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/rhc_pkg.sv
rtl/core/rhc_front.sv
rtl/core/rhc_div.sv
rtl/core/rgb_to_hsv_convert.sv
tb/rgb_to_hsv_convert_tb.sv
